/* sv/itrd_pkg.sv */
// Shared types and constants for the integer to radix digits block.
package itrd_pkg;

    localparam int VALUE_W      = 32;
    localparam int CHAR_W       = 8;
    localparam int BASE_W       = 5;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int SYMBOL_SLOTS = 16;
    localparam int SYM_IDX_W    = 4;
    localparam int MAX_DIGITS   = 32;
    localparam int DIGIT_IDX_W  = 5;
    localparam int DIGIT_CNT_W  = 6;
    localparam int SLICE_BITS   = 8;
    localparam int SLICE_CNT_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_PLUS            = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS           = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_FIRST_PRINTABLE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LAST_PRINTABLE  = 8'h7E;

    localparam logic [SLICE_CNT_W-1:0] LAST_SLICE = 2'd3;

    typedef struct packed {
        logic load;
        logic step;
        logic push;
        logic emit_sign;
        logic emit_digit;
    } itrd_cmd_t;

    typedef struct packed {
        logic ok;
        logic neg;
        logic quot_zero;
        logic digits_full;
        logic last_digit;
    } itrd_sts_t;

endpackage

/* sv/integer_to_radix_digits.sv */
// Top level: signed integer to text in a configurable radix.
//
// Give a value with start while busy is low; the item is taken at that edge.
// If the alphabet (base_size symbols from symbols_low/high) is invalid, the
// item produces nothing and busy stays low. Otherwise busy rises while the
// divider works out each digit in slices, retiring eight quotient bits a
// cycle, and stays high while the sign of a negative value and then the
// digits are emitted. Characters appear on character/last, one per cycle,
// each marked by a single-cycle strobe in the cycle after its emission
// slot; the receiver cannot hold them off. The longest item is the most
// negative value in radix 2. The last strobe of an item may coincide with
// the next start. The config port is always ready and may be written only
// while the block is idle.
module integer_to_radix_digits #(
    parameter int MAX_BASE = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [itrd_pkg::VALUE_W-1:0]        value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [itrd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [itrd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                strobe,
    output logic [itrd_pkg::CHAR_W-1:0]         character,
    output logic                                last
);
    import itrd_pkg::*;

    itrd_cmd_t cmd;
    itrd_sts_t sts;

    // Registers take a write in any cycle
    assign cfg_ready = 1'b1;

    itrd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    itrd_dp #(
        .MAX_BASE (MAX_BASE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

`ifndef SYNTHESIS
    a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("character shown without an item in progress");
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("character follows the final one of an item");
    a_start_sees_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && sts.ok) |=> busy)
        else $error("valid item accepted but no work begun");
`endif

endmodule

/* sv/itrd_ctrl.sv */
// Sequencer: division slices per digit, then sign and digit emission.
module itrd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  itrd_pkg::itrd_sts_t sts,
    output itrd_pkg::itrd_cmd_t cmd,
    output logic                busy
);
    import itrd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [SLICE_CNT_W-1:0]  slice_reg;
    logic                    busy_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.load       = (state_reg == ST_IDLE) && start;
        cmd.step       = (state_reg == ST_DIV);
        cmd.push       = (state_reg == ST_DIV) && (slice_reg == LAST_SLICE);
        cmd.emit_sign  = (state_reg == ST_SIGN);
        cmd.emit_digit = (state_reg == ST_EMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slice_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    slice_reg <= '0;
                    if (start && sts.ok)
                    begin
                        state_reg <= ST_DIV;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_DIV:
                begin
                    slice_reg <= slice_reg + 1'b1;
                    if ((slice_reg == LAST_SLICE) && (sts.quot_zero || sts.digits_full))
                        state_reg <= sts.neg ? ST_SIGN : ST_EMIT;
                end
                ST_SIGN:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (sts.last_digit)
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;

`ifndef SYNTHESIS
    a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != ST_IDLE))
        else $error("busy out of step with sequencer state");
    a_bad_alphabet_no_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start && !sts.ok) |=> (state_reg == ST_IDLE))
        else $error("work started on an invalid alphabet");
    a_emit_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && $past(state_reg) == ST_DIV) |-> $past(cmd.push))
        else $error("emission began before a digit was stored");
`endif

endmodule

/* sv/itrd_dp.sv */
// Datapath: config registers, alphabet check, sliced divider, digit store, output.
module itrd_dp #(
    parameter int MAX_BASE = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [itrd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [itrd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [itrd_pkg::VALUE_W-1:0]        value,
    input  itrd_pkg::itrd_cmd_t                 cmd,
    output itrd_pkg::itrd_sts_t                 sts,
    output logic                                strobe,
    output logic [itrd_pkg::CHAR_W-1:0]         character,
    output logic                                last
);
    import itrd_pkg::*;

    localparam int DIGIT_W = $clog2(MAX_BASE);
    localparam int REM_W   = DIGIT_W + 1;

    logic [BASE_W-1:0]      base_size_reg;
    logic [CFG_DATA_W-1:0]  sym_low_reg;
    logic [CFG_DATA_W-1:0]  sym_high_reg;

    logic [VALUE_W-1:0]     mag_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [REM_W-1:0]       div_reg;
    logic                   neg_reg;
    logic [DIGIT_CNT_W-1:0] nd_reg;
    logic [DIGIT_W-1:0]     digit_mem [MAX_DIGITS];

    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;
    logic                   strobe_reg;

    logic [CHAR_W-1:0]      syms [SYMBOL_SLOTS];
    logic                   ok;
    logic [VALUE_W-1:0]     mag_next;
    logic [REM_W-1:0]       rem_next;
    logic [REM_W:0]         trial;
    logic [DIGIT_IDX_W-1:0] rd_idx;
    logic [DIGIT_W-1:0]     rd_digit;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_size_reg <= '0;
            sym_low_reg   <= '0;
            sym_high_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BASE_SIZE:    base_size_reg <= cfg_data[BASE_W-1:0];
                REG_SYMBOLS_LOW:  sym_low_reg   <= cfg_data;
                REG_SYMBOLS_HIGH: sym_high_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Alphabet check: radix range, printable non-sign symbols, and every symbol pair compared in parallel
    always_comb
    begin
        for (int i = 0; i < SYMBOL_SLOTS; i++)
            syms[i] = (i < 8) ? sym_low_reg[(i % 8) * CHAR_W +: CHAR_W]
                              : sym_high_reg[(i % 8) * CHAR_W +: CHAR_W];
        ok = (base_size_reg >= BASE_W'(2)) && (base_size_reg <= BASE_W'(MAX_BASE));
        for (int i = 0; i < SYMBOL_SLOTS; i++)
        begin
            if (BASE_W'(i) < base_size_reg)
            begin
                if (syms[i] == CHAR_PLUS || syms[i] == CHAR_MINUS)
                    ok = 1'b0;
                if (syms[i] < CHAR_FIRST_PRINTABLE || syms[i] > CHAR_LAST_PRINTABLE)
                    ok = 1'b0;
                for (int j = i + 1; j < SYMBOL_SLOTS; j++)
                    if (BASE_W'(j) < base_size_reg && syms[j] == syms[i])
                        ok = 1'b0;
            end
        end
    end

    // One slice of restoring division: eight quotient bits, MSB first
    always_comb
    begin
        rem_next = rem_reg;
        mag_next = mag_reg;
        trial    = '0;
        for (int k = 0; k < SLICE_BITS; k++)
        begin
            trial    = {rem_next, mag_next[VALUE_W-1]};
            mag_next = {mag_next[VALUE_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next    = REM_W'(trial - {1'b0, div_reg});
                mag_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[REM_W-1:0];
            end
        end
    end

    assign rd_idx   = DIGIT_IDX_W'(nd_reg - 1'b1);
    assign rd_digit = digit_mem[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nd_reg     <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_sign || cmd.emit_digit;
            if (cmd.load)
                nd_reg <= '0;
            else if (cmd.push)
                nd_reg <= nd_reg + 1'b1;
            else if (cmd.emit_digit)
                nd_reg <= nd_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg <= value[VALUE_W-1];
            mag_reg <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
            rem_reg <= '0;
            div_reg <= REM_W'(base_size_reg);
        end
        else if (cmd.step)
        begin
            mag_reg <= mag_next;
            rem_reg <= cmd.push ? '0 : rem_next;
        end
        if (cmd.push)
            digit_mem[nd_reg[DIGIT_IDX_W-1:0]] <= DIGIT_W'(rem_next);
        if (cmd.emit_sign)
        begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= syms[SYM_IDX_W'(rd_digit)];
            last_reg <= (nd_reg == DIGIT_CNT_W'(1));
        end
    end

    always_comb
    begin
        sts.ok          = ok;
        sts.neg         = neg_reg;
        sts.quot_zero   = (mag_next == '0);
        sts.digits_full = (nd_reg == DIGIT_CNT_W'(MAX_DIGITS - 1));
        sts.last_digit  = (nd_reg == DIGIT_CNT_W'(1));
    end

    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_push_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (nd_reg < DIGIT_CNT_W'(MAX_DIGITS)))
        else $error("digit store overflow");
    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit |-> (nd_reg != '0))
        else $error("digit emitted from an empty store");
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && char_reg == CHAR_MINUS) |-> !last_reg)
        else $error("minus sign flagged as final character");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the integer to radix digits block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import itrd_pkg::*;

    localparam int MAX_BASE       = 16;
    // Pause longer than the worst item keeps busy high
    localparam int DRAIN_CYCLES   = 200;
    // Cycles with no item, character or register write before giving up
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    // Ways of spoiling an otherwise good alphabet
    typedef enum int {
        FAULT_NONE,
        FAULT_DUP,
        FAULT_PLUS,
        FAULT_MINUS,
        FAULT_CTRL,
        FAULT_HIGH,
        FAULT_TINY_BASE,
        FAULT_WIDE_BASE
    } fault_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic [VALUE_W-1:0]    value     = '0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  busy;
    logic                  cfg_ready;
    logic                  strobe;
    logic [CHAR_W-1:0]     character;
    logic                  last;

    // Shadow copy of the registers, updated at each write handshake
    logic [BASE_W-1:0]     cur_base = '0;
    logic [CFG_DATA_W-1:0] cur_low  = '0;
    logic [CFG_DATA_W-1:0] cur_high = '0;

    logic [VALUE_W-1:0] pending_values [$];   // items still to be offered
    text_char_t         expected_chars [$];   // characters still owed by the block

    int idle_pct      = 8;   // chance in a hundred that the sender idles this cycle
    int errors        = 0;
    int quiet_cycles  = 0;
    int values_taken  = 0;
    int chars_seen    = 0;
    int settings_used = 0;

    integer_to_radix_digits #(
        .MAX_BASE (MAX_BASE)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Symbol for digit idx under the current register contents
    function automatic logic [CHAR_W-1:0] glyph_of(int unsigned idx);
        logic [CFG_DATA_W-1:0] word;
        word = (idx < 8) ? cur_low : cur_high;
        return word[(idx % 8) * 8 +: 8];
    endfunction

    // Radix within 2..MAX_BASE, every symbol printable, no sign, no repeats
    function automatic bit alphabet_valid();
        int unsigned       n;
        logic [CHAR_W-1:0] s;
        n = 32'(cur_base);
        if (n < 2 || n > MAX_BASE)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            s = glyph_of(i);
            if (s == CHAR_PLUS || s == CHAR_MINUS)
                return 1'b0;
            if (s < CHAR_FIRST_PRINTABLE || s > CHAR_LAST_PRINTABLE)
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (glyph_of(j) == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Queues the text of one accepted item; nothing at all for a bad alphabet
    function automatic void predict_text(logic [VALUE_W-1:0] v);
        logic [VALUE_W:0] mag;      // one bit wider so that -2^31 survives negation
        int unsigned      digs [MAX_DIGITS];
        int unsigned      nd;
        int unsigned      n;
        bit               neg;
        if (!alphabet_valid())
            return;
        n   = 32'(cur_base);
        neg = v[VALUE_W-1];
        mag = neg ? ({1'b1, {VALUE_W{1'b0}}} - {1'b0, v}) : {1'b0, v};
        nd  = 0;
        do
        begin
            digs[nd] = 32'(mag % n);
            nd++;
            mag = mag / n;
        end
        while (mag != 0 && nd < MAX_DIGITS);
        if (neg)
            expected_chars.push_back('{ch: CHAR_MINUS, last: 1'b0});
        for (int k = nd; k > 0; k--)
            expected_chars.push_back('{ch: glyph_of(digs[k-1]), last: (k == 1)});
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the next pending item, idling at random
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                // item taken at this edge, registers are stable while it runs
                predict_text(value);
                values_taken++;
            end
            // hold the item while busy; otherwise choose what comes next
            if (!start || !busy)
            begin
                if (pending_values.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    start <= 1'b1;
                    value <= pending_values.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every strobed character, plus the watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                chars_seen++;
                if (expected_chars.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("ERROR: unexpected character %h last %b", character, last);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (character !== want.ch || last !== want.last)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("ERROR: character exp %h got %h, last exp %b got %b",
                                     want.ch, character, want.last, last);
                    end
                end
            end
            if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: watchdog, no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Register access and phase control
    // ------------------------------------------------------------------

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BASE_SIZE:    cur_base = data[BASE_W-1:0];
            REG_SYMBOLS_LOW:  cur_low  = data;
            REG_SYMBOLS_HIGH: cur_high = data;
            default: ;
        endcase
    endtask

    task automatic set_alphabet(logic [CFG_DATA_W-1:0] base_word,
                                logic [CFG_DATA_W-1:0] lo,
                                logic [CFG_DATA_W-1:0] hi);
        write_reg(REG_BASE_SIZE, base_word);
        write_reg(REG_SYMBOLS_LOW, lo);
        write_reg(REG_SYMBOLS_HIGH, hi);
        settings_used++;
        @(negedge clk);
    endtask

    // Wait until every item has gone in and every character come out, then let a
    // full worst-case item time pass, since a rejected item leaves no trace
    task automatic drain();
        do
            @(negedge clk);
        while (!(pending_values.size() == 0 && !start && !busy && expected_chars.size() == 0));
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Random alphabet of distinct printable symbols, optionally with one fault;
    // the unused slots get arbitrary bytes, which the block has to ignore
    task automatic pick_alphabet(bit allow_fault,
                                 output logic [CFG_DATA_W-1:0] base_word,
                                 output logic [CFG_DATA_W-1:0] lo,
                                 output logic [CFG_DATA_W-1:0] hi);
        logic [CHAR_W-1:0] syms [SYMBOL_SLOTS];
        bit                used [256];
        int unsigned       n;
        int unsigned       pos;
        logic [CHAR_W-1:0] c;
        fault_t            fault;
        n = $urandom_range(2, MAX_BASE);
        for (int i = 0; i < 256; i++)
            used[i] = 1'b0;
        for (int i = 0; i < SYMBOL_SLOTS; i++)
        begin
            if (i < n)
            begin
                do
                    c = CHAR_W'($urandom_range(CHAR_FIRST_PRINTABLE, CHAR_LAST_PRINTABLE));
                while (c == CHAR_PLUS || c == CHAR_MINUS || used[c]);
                used[c] = 1'b1;
            end
            else
            begin
                c = CHAR_W'($urandom);
            end
            syms[i] = c;
        end
        fault = allow_fault ? fault_t'($urandom_range(FAULT_DUP, FAULT_WIDE_BASE)) : FAULT_NONE;
        pos   = $urandom_range(0, n - 1);
        case (fault)
            FAULT_DUP:       syms[pos] = syms[(pos + 1) % n];
            FAULT_PLUS:      syms[pos] = CHAR_PLUS;
            FAULT_MINUS:     syms[pos] = CHAR_MINUS;
            FAULT_CTRL:      syms[pos] = CHAR_W'($urandom_range(0, CHAR_FIRST_PRINTABLE - 1));
            FAULT_HIGH:      syms[pos] = CHAR_W'($urandom_range(CHAR_LAST_PRINTABLE + 1, 8'hFF));
            FAULT_TINY_BASE: n = $urandom_range(0, 1);
            FAULT_WIDE_BASE: n = $urandom_range(MAX_BASE + 1, 31);
            default: ;
        endcase
        // junk above the radix field must be dropped by the block
        base_word = {$urandom, $urandom};
        base_word[BASE_W-1:0] = BASE_W'(n);
        for (int i = 0; i < 8; i++)
        begin
            lo[i*8 +: 8] = syms[i];
            hi[i*8 +: 8] = syms[i + 8];
        end
    endtask

    // Mix of full-range, small, extreme and power-of-radix values
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [63:0]        p;
        logic [VALUE_W-1:0] v;
        int unsigned        b;
        case ($urandom_range(5))
            1:
            begin
                v = $urandom_range(0, 40);
                return $urandom_range(1) ? -v : v;
            end
            2:
            begin
                case ($urandom_range(6))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h0000_0001;
                    3: return 32'h7FFF_FFFF;
                    4: return 32'h8000_0000;
                    5: return 32'h8000_0001;
                    default: return 32'h7FFF_FFFE;
                endcase
            end
            3:
            begin
                // just either side of a digit-count boundary
                b = (cur_base >= 2 && cur_base <= MAX_BASE) ? 32'(cur_base) : 10;
                p = 1;
                repeat ($urandom_range(1, 31))
                    if (p * b <= 64'h8000_0000)
                        p = p * b;
                p = p + $urandom_range(2) - 1;
                return $urandom_range(1) ? -p[VALUE_W-1:0] : p[VALUE_W-1:0];
            end
            4:
                return $urandom | 32'h8000_0000;
            default:
                return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [CFG_DATA_W-1:0] b;
        logic [CFG_DATA_W-1:0] l;
        logic [CFG_DATA_W-1:0] h;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers at reset give an empty alphabet: nothing may come out
        pending_values.push_back(32'd12345);
        drain();

        // Decimal: zero, unit values, both extremes, a boundary
        set_alphabet(64'd10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938);
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(-32'sd1);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(-32'sd10);
        drain();

        // Binary: longest text; junk in the unused slots must be ignored
        set_alphabet(64'd2, 64'hFF7F_2B2D_1F00_3130, 64'hFFFF_FFFF_FFFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'd0);
        drain();

        // Full-width radix
        set_alphabet(64'd16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
        pending_values.push_back(32'hDEAD_BEEF);
        pending_values.push_back(32'd15);
        pending_values.push_back(32'd16);
        pending_values.push_back(32'h8000_0000);
        drain();

        // Printable range edges as symbols
        set_alphabet(64'd3, 64'h0000_0000_0061_7E20, 64'h0);
        pending_values.push_back(-32'sd123);
        drain();

        // Rejected alphabets: one item each, none may produce text
        set_alphabet(64'd1, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
        pending_values.push_back(32'd5);
        drain();
        set_alphabet(64'd17, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
        pending_values.push_back(-32'sd7);
        drain();
        set_alphabet(64'd31, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
        pending_values.push_back(32'd99);
        drain();
        set_alphabet(64'd0, 64'h0, 64'h0);
        pending_values.push_back(32'd1);
        drain();
        // plus sign among the symbols
        set_alphabet(64'd10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_2B38);
        pending_values.push_back(32'd42);
        drain();
        // minus sign as symbol zero
        set_alphabet(64'd10, 64'h3736_3534_3332_312D, 64'h0000_0000_0000_3938);
        pending_values.push_back(-32'sd42);
        drain();
        // control byte
        set_alphabet(64'd8, 64'h3736_1F34_3332_3130, 64'h0);
        pending_values.push_back(32'd77);
        drain();
        // DEL in the top slot
        set_alphabet(64'd16, 64'h3736_3534_3332_3130, 64'h7F45_4443_4241_3938);
        pending_values.push_back(32'd255);
        drain();
        // repeated symbol
        set_alphabet(64'd4, 64'h0000_0000_3032_3130, 64'h0);
        pending_values.push_back(32'd17);
        drain();

        // Random part: fresh alphabet per batch, sender idling 8%, then 79%, then never
        for (int cfg = 0; cfg < 8; cfg++)
        begin
            idle_pct = (cfg < 3) ? 8 : (cfg < 6) ? 79 : 0;
            pick_alphabet(cfg != 0 && $urandom_range(3) == 0, b, l, h);
            set_alphabet(b, l, h);
            repeat (10) pending_values.push_back(pick_value());
            drain();
        end

        // anything still owed counts against the block
        errors += expected_chars.size();
        $display("Run: %0d items, %0d characters checked, %0d alphabet settings.",
                 values_taken, chars_seen, settings_used);
        $display("Covered radices 2 to %0d, signed extremes and rejected alphabets.",
                 MAX_BASE);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
